// ----- hdl/pidaw_pkg.sv -----
// Shared widths, beat structs and unit status type for the PID controller.
// No dependencies; every other file imports this package.
package pidaw_pkg;

    localparam int DATA_W          = 16;
    localparam int ERR_W           = DATA_W + 1;
    localparam int DIFF_W          = DATA_W + 2;
    localparam int INT_W           = 25;
    localparam int SLOPE_W         = 32;
    localparam int GAIN_W          = 16;
    localparam int ILIM_W          = 15;
    localparam int ALPHA_W         = 17;
    localparam int CFG_W           = 17;
    localparam int CFG_IDX_W       = 3;
    localparam int MUL_NB          = 17;
    localparam int QUOT_W          = 24;
    localparam int FRAC_SHIFT      = 16;
    localparam int SAMPLE_RATE_DEF = 200;

    typedef struct packed {
        logic signed [DATA_W-1:0] target_value;
        logic signed [DATA_W-1:0] measured_value;
    } t_in_beat;

    typedef struct packed {
        logic signed [DATA_W-1:0] drive_value;
        logic                     drive_clamped;
    } t_out_beat;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_stat;

endpackage

// ----- hdl/pidaw_mul.sv -----
// Serial-parallel multiplier: signed multiplicand, unsigned multiplier taken
// one bit per cycle, product shifted out into a low shift register.
// Depends on pidaw_pkg.
module pidaw_mul
    import pidaw_pkg::*;
#(
    parameter int A_W = SLOPE_W,
    parameter int B_W = MUL_NB
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [A_W-1:0] i_a,
    input  logic [B_W-1:0]       i_b,
    output t_mul_stat            o_stat,
    output logic signed [A_W+B_W:0] o_product
);

    localparam int CNT_W = $clog2(B_W + 1);

    logic signed [A_W-1:0] r_a;
    logic [B_W-1:0]        r_b;
    logic signed [A_W:0]   r_hi;
    logic [B_W-1:0]        r_lo;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic signed [A_W:0]   addend;
    logic signed [A_W:0]   sum_step;

    assign addend   = r_b[0] ? {r_a[A_W-1], r_a} : '0;
    assign sum_step = r_hi + addend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(B_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_b  <= i_b;
            r_hi <= '0;
        end else if (r_busy) begin
            r_hi <= {sum_step[A_W], sum_step[A_W:1]};
            r_lo <= {sum_step[0], r_lo[B_W-1:1]};
            r_b  <= r_b >> 1;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_product   = {r_hi, r_lo};

endmodule

// ----- hdl/pidaw_div.sv -----
// Restoring divider by a fixed divisor, one quotient bit per cycle.
// Depends on pidaw_pkg.
module pidaw_div
    import pidaw_pkg::*;
#(
    parameter int DIVISOR = SAMPLE_RATE_DEF,
    parameter int NUM_W   = QUOT_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    output logic             o_busy,
    output logic [NUM_W-1:0] o_quot
);

    localparam int REM_W = $clog2(DIVISOR + 1);
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam logic [REM_W:0] DIV_K = (REM_W + 1)'(DIVISOR);

    logic [NUM_W-1:0] r_num;
    logic [REM_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [REM_W:0]   trial;
    logic [REM_W:0]   trial_sub;
    logic             fits;

    assign trial     = {r_rem, r_num[NUM_W-1]};
    assign fits      = (trial >= DIV_K);
    assign trial_sub = trial - DIV_K;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? trial_sub[REM_W-1:0] : trial[REM_W-1:0];
            r_num <= {r_num[NUM_W-2:0], fits};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_num;

endmodule

// ----- hdl/pid_antiwindup_filtered_derivative.sv -----
// PID controller top level: register file, sequencer, state and output beat register.
// Depends on pidaw_pkg, pidaw_mul and pidaw_div.
//
//   channel | direction | handshake                 | payload
//   in      | input     | i_in_valid / o_in_ready   | i_in_data  (t_in_beat)
//   out     | output    | o_out_valid / i_out_ready | o_out_data (t_out_beat)
//   cfg     | input     | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// One beat at a time: six serial multiplications on the shared multiplier set the pace;
// a beat leaves the sequencer after the last of them, and the next beat is taken only
// once the sequencer is back in idle.
// The integral division runs beside the first two multiplications.
// A finished beat waits in the output register; a new beat is accepted meanwhile.
// The final step stalls while the output register is still full.
// Synchronous active-low reset clears state and history and presets the config regs.
module pid_antiwindup_filtered_derivative
    import pidaw_pkg::*;
#(
    parameter int SAMPLE_RATE = SAMPLE_RATE_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_beat             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_beat            o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int SR_W  = $clog2(SAMPLE_RATE + 1);
    localparam int RAW_W = DIFF_W + SR_W;
    localparam int MW    = (RAW_W > SLOPE_W) ? RAW_W : SLOPE_W;
    localparam int PW    = MW + MUL_NB + 1;
    localparam int ACC_W = PW + 10;
    localparam int RND_W = ACC_W - FRAC_SHIFT;

    localparam logic [CFG_IDX_W-1:0] CFG_KP      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_KI      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_KD      = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_ILIM    = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR   = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA   = CFG_IDX_W'(6);

    localparam logic [ALPHA_W-1:0] ALPHA_ONE  = ALPHA_W'(65536);
    localparam logic [ACC_W-1:0]   ROUND_HALF = ACC_W'(32768);
    localparam logic [SLOPE_W-1:0] SLOPE_MAX  = {1'b0, {(SLOPE_W-1){1'b1}}};
    localparam logic [SLOPE_W-1:0] SLOPE_MIN  = {1'b1, {(SLOPE_W-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_RAW,
        S_MIXA,
        S_MIXB,
        S_INT,
        S_KP,
        S_KI,
        S_KD,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_mul_start;
    logic   n_mul_start;
    logic   r_out_valid;
    t_out_beat r_out;

    logic [GAIN_W-1:0]         r_kp;
    logic [GAIN_W-1:0]         r_ki;
    logic [GAIN_W-1:0]         r_kd;
    logic [ILIM_W-1:0]         r_ilim;
    logic signed [DATA_W-1:0]  r_floor;
    logic signed [DATA_W-1:0]  r_ceil;
    logic [ALPHA_W-1:0]        r_alpha;

    logic signed [ERR_W-1:0]   r_err;
    logic signed [DIFF_W-1:0]  r_diff;
    logic                      r_neg;
    logic                      r_integ_en;
    logic signed [MW-1:0]      r_raw;
    logic signed [ACC_W-1:0]   r_acc;

    logic signed [INT_W-1:0]   r_integral;
    logic signed [ERR_W-1:0]   r_prev_err;
    logic signed [SLOPE_W-1:0] r_slope;
    logic signed [DATA_W-1:0]  r_prev_drive;

    logic                      in_acc;
    logic signed [ERR_W-1:0]   in_err;
    logic [ERR_W-1:0]          in_abs;
    logic signed [DIFF_W-1:0]  in_diff;
    logic                      integ_en;

    logic signed [MW-1:0]      mul_a;
    logic [MUL_NB-1:0]         mul_b;
    t_mul_stat                 mul_stat;
    logic signed [PW-1:0]      product;
    logic signed [ACC_W-1:0]   prod_x;
    logic signed [ACC_W-1:0]   prod_sh;

    logic                      div_busy;
    logic [QUOT_W-1:0]         quot;

    logic [ALPHA_W-1:0]        alpha_c;
    logic signed [ACC_W-1:0]   acc_rnd;
    logic signed [RND_W-1:0]   acc_q;
    logic signed [SLOPE_W-1:0] slope_sat;

    logic signed [INT_W-1:0]   inc;
    logic signed [INT_W:0]     int_sum;
    logic signed [INT_W:0]     lim_pos;
    logic signed [INT_W:0]     lim_neg;
    logic signed [INT_W-1:0]   int_next;

    logic signed [RND_W-1:0]   ceil_x;
    logic signed [RND_W-1:0]   floor_x;
    logic signed [RND_W-1:0]   drive_v1;
    logic                      hit_ceil;
    logic                      hit_floor;
    logic signed [DATA_W-1:0]  drive_fin;
    logic                      out_load;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    assign in_err  = {i_in_data.target_value[DATA_W-1], i_in_data.target_value}
                   - {i_in_data.measured_value[DATA_W-1], i_in_data.measured_value};
    assign in_abs  = in_err[ERR_W-1] ? -in_err : in_err;
    assign in_diff = {in_err[ERR_W-1], in_err} - {r_prev_err[ERR_W-1], r_prev_err};
    assign integ_en = (r_prev_drive < r_ceil) && (r_prev_drive > r_floor);

    assign alpha_c = (r_alpha > ALPHA_ONE) ? ALPHA_ONE : r_alpha;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_RAW: begin
                mul_a = {{(MW-DIFF_W){r_diff[DIFF_W-1]}}, r_diff};
                mul_b = MUL_NB'(SAMPLE_RATE);
            end
            S_MIXA: begin
                mul_a = r_raw;
                mul_b = alpha_c;
            end
            S_MIXB: begin
                mul_a = {{(MW-SLOPE_W){r_slope[SLOPE_W-1]}}, r_slope};
                mul_b = ALPHA_ONE - alpha_c;
            end
            S_KP: begin
                mul_a = {{(MW-ERR_W){r_err[ERR_W-1]}}, r_err};
                mul_b = {{(MUL_NB-GAIN_W){1'b0}}, r_kp};
            end
            S_KI: begin
                mul_a = {{(MW-INT_W){r_integral[INT_W-1]}}, r_integral};
                mul_b = {{(MUL_NB-GAIN_W){1'b0}}, r_ki};
            end
            S_KD: begin
                mul_a = {{(MW-SLOPE_W){r_slope[SLOPE_W-1]}}, r_slope};
                mul_b = {{(MUL_NB-GAIN_W){1'b0}}, r_kd};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    pidaw_mul #(
        .A_W (MW),
        .B_W (MUL_NB)
    ) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_mul_start),
        .i_a       (mul_a),
        .i_b       (mul_b),
        .o_stat    (mul_stat),
        .o_product (product)
    );

    pidaw_div #(
        .DIVISOR (SAMPLE_RATE),
        .NUM_W   (QUOT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_acc),
        .i_num   ({in_abs[DATA_W-1:0], 8'd0}),
        .o_busy  (div_busy),
        .o_quot  (quot)
    );

    assign prod_x  = {{(ACC_W-PW){product[PW-1]}}, product};
    assign prod_sh = {{(ACC_W-PW-8){product[PW-1]}}, product, 8'd0};

    assign acc_rnd = r_acc + ROUND_HALF;
    assign acc_q   = acc_rnd[ACC_W-1:FRAC_SHIFT];

    always_comb begin
        if ((&acc_q[RND_W-1:SLOPE_W-1]) || !(|acc_q[RND_W-1:SLOPE_W-1])) begin
            slope_sat = acc_q[SLOPE_W-1:0];
        end else if (acc_q[RND_W-1]) begin
            slope_sat = SLOPE_MIN;
        end else begin
            slope_sat = SLOPE_MAX;
        end
    end

    assign inc     = r_neg ? -{1'b0, quot} : {1'b0, quot};
    assign int_sum = {r_integral[INT_W-1], r_integral} + {inc[INT_W-1], inc};
    assign lim_pos = {3'd0, r_ilim, 8'd0};
    assign lim_neg = -lim_pos;

    always_comb begin
        if (int_sum > lim_pos) begin
            int_next = lim_pos[INT_W-1:0];
        end else if (int_sum < lim_neg) begin
            int_next = lim_neg[INT_W-1:0];
        end else begin
            int_next = int_sum[INT_W-1:0];
        end
    end

    assign ceil_x    = {{(RND_W-DATA_W){r_ceil[DATA_W-1]}}, r_ceil};
    assign floor_x   = {{(RND_W-DATA_W){r_floor[DATA_W-1]}}, r_floor};
    assign hit_ceil  = (acc_q > ceil_x);
    assign drive_v1  = hit_ceil ? ceil_x : acc_q;
    assign hit_floor = (drive_v1 < floor_x);
    assign drive_fin = hit_floor ? r_floor : drive_v1[DATA_W-1:0];
    assign out_load  = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    assign n_mul_start = in_acc
        || (((r_state == S_RAW) || (r_state == S_MIXA) || (r_state == S_KP)
             || (r_state == S_KI)) && mul_stat.done)
        || ((r_state == S_INT) && !div_busy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp    <= GAIN_W'(256);
            r_ki    <= GAIN_W'(256);
            r_kd    <= '0;
            r_ilim  <= ILIM_W'(2560);
            r_floor <= '0;
            r_ceil  <= DATA_W'(25600);
            r_alpha <= ALPHA_W'(6554);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KP:      r_kp    <= i_cfg_data[GAIN_W-1:0];
                CFG_KI:      r_ki    <= i_cfg_data[GAIN_W-1:0];
                CFG_KD:      r_kd    <= i_cfg_data[GAIN_W-1:0];
                CFG_ILIM:    r_ilim  <= i_cfg_data[ILIM_W-1:0];
                CFG_FLOOR:   r_floor <= i_cfg_data[DATA_W-1:0];
                CFG_CEILING: r_ceil  <= i_cfg_data[DATA_W-1:0];
                CFG_ALPHA:   r_alpha <= i_cfg_data[ALPHA_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mul_start  <= 1'b0;
            r_out_valid  <= 1'b0;
            r_integral   <= '0;
            r_prev_err   <= '0;
            r_slope      <= '0;
            r_prev_drive <= '0;
        end else begin
            r_mul_start <= n_mul_start;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_RAW;
                    end
                end
                S_RAW: begin
                    if (mul_stat.done) begin
                        r_state <= S_MIXA;
                    end
                end
                S_MIXA: begin
                    if (mul_stat.done) begin
                        r_state <= S_MIXB;
                    end
                end
                S_MIXB: begin
                    if (mul_stat.done) begin
                        r_state <= S_INT;
                    end
                end
                S_INT: begin
                    r_slope <= slope_sat;
                    if (!div_busy) begin
                        if (r_integ_en) begin
                            r_integral <= int_next;
                        end
                        r_state <= S_KP;
                    end
                end
                S_KP: begin
                    if (mul_stat.done) begin
                        r_state <= S_KI;
                    end
                end
                S_KI: begin
                    if (mul_stat.done) begin
                        r_state <= S_KD;
                    end
                end
                S_KD: begin
                    if (mul_stat.done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_prev_err   <= r_err;
                        r_prev_drive <= drive_fin;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_err      <= in_err;
            r_diff     <= in_diff;
            r_neg      <= in_err[ERR_W-1];
            r_integ_en <= integ_en;
        end
        if (mul_stat.done) begin
            case (r_state)
                S_RAW:  r_raw <= product[MW-1:0];
                S_MIXA: r_acc <= prod_x;
                S_MIXB: r_acc <= r_acc + prod_x;
                S_KP:   r_acc <= prod_sh;
                S_KI:   r_acc <= r_acc + prod_x;
                S_KD:   r_acc <= r_acc + prod_sh;
                default: begin
                end
            endcase
        end
        if (out_load) begin
            r_out.drive_value   <= drive_fin;
            r_out.drive_clamped <= hit_ceil || hit_floor;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_integral_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_integral[INT_W-1] == r_integral[INT_W-2])
        else $error("integral left its clamp range");

    a_mul_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mul_start |-> !mul_stat.busy)
        else $error("multiplier launched while busy");

    a_div_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_KP) && r_mul_start |-> !div_busy)
        else $error("integral used before division finished");

    a_drive_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> r_out_valid && (r_out.drive_clamped ||
            ((r_out.drive_value >= r_floor) && (r_out.drive_value <= r_ceil))))
        else $error("unflagged drive outside limits");

endmodule
